/* sv/grapheme_cluster_boundary_detector_unit_assert.svh */
// ----------------------------------------------------------------------------
// grapheme cluster boundary detector assertion macros
// shared concurrent check forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef GRAPHEME_CLUSTER_BOUNDARY_DETECTOR_UNIT_ASSERT_SVH
`define GRAPHEME_CLUSTER_BOUNDARY_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define GCBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcbd check failed: same-cycle implication");

// next-cycle implication
`define GCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcbd check failed: next-cycle implication");

`endif

/* sv/gcbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbd_pkg
// types, categories and limits of the grapheme cluster boundary detector
// ----------------------------------------------------------------------------
package gcbd_pkg;

    localparam int CLUSTER_COUNT_MAX = 255;
    localparam int POINTS_W          = 8;
    localparam int BYTES_W           = 10;
    localparam int CAT_W             = 4;
    localparam int SRC_BYTES_W       = 3;

    localparam int POINTS_LIMIT_INT = (CLUSTER_COUNT_MAX > 255) ? 255 : CLUSTER_COUNT_MAX;
    localparam logic [POINTS_W-1:0] POINTS_LIMIT = POINTS_LIMIT_INT[POINTS_W-1:0];
    localparam logic [BYTES_W-1:0]  BYTES_LIMIT  = {BYTES_W{1'b1}};

    localparam logic [CAT_W-1:0] CAT_OTHER   = 4'd0;
    localparam logic [CAT_W-1:0] CAT_CR      = 4'd1;
    localparam logic [CAT_W-1:0] CAT_LF      = 4'd2;
    localparam logic [CAT_W-1:0] CAT_CONTROL = 4'd3;
    localparam logic [CAT_W-1:0] CAT_EXTEND  = 4'd4;
    localparam logic [CAT_W-1:0] CAT_ZWJ     = 4'd5;
    localparam logic [CAT_W-1:0] CAT_RI      = 4'd6;
    localparam logic [CAT_W-1:0] CAT_PREPEND = 4'd7;
    localparam logic [CAT_W-1:0] CAT_SPACING = 4'd8;
    localparam logic [CAT_W-1:0] CAT_L       = 4'd9;
    localparam logic [CAT_W-1:0] CAT_V       = 4'd10;
    localparam logic [CAT_W-1:0] CAT_T       = 4'd11;
    localparam logic [CAT_W-1:0] CAT_LV      = 4'd12;
    localparam logic [CAT_W-1:0] CAT_LVT     = 4'd13;

    typedef struct packed {
        logic                   text_start;
        logic [CAT_W-1:0]       break_category;
        logic                   ext_pictographic;
        logic [SRC_BYTES_W-1:0] source_bytes;
        logic                   code_valid;
    } t_gcbd_item;

    typedef struct packed {
        logic                boundary_before;
        logic [POINTS_W-1:0] cluster_points;
        logic [BYTES_W-1:0]  cluster_bytes;
        logic                decode_error;
    } t_gcbd_result;

    typedef struct packed {
        logic                have_previous;
        logic [CAT_W-1:0]    previous_category;
        logic                previous_pictographic;
        logic                emoji_seq_state;
        logic                regional_parity;
        logic [POINTS_W-1:0] point_count;
        logic [BYTES_W-1:0]  byte_count;
    } t_gcbd_state;

    localparam t_gcbd_state GCBD_STATE_RESET = '0;

endpackage

/* sv/gcbd_rules.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbd_rules
// boundary rules gb1..gb13 and cluster count update for one code point
// ----------------------------------------------------------------------------
module gcbd_rules (
    input  gcbd_pkg::t_gcbd_item   i_item,
    input  gcbd_pkg::t_gcbd_state  i_state,
    output gcbd_pkg::t_gcbd_result o_result,
    output gcbd_pkg::t_gcbd_state  o_state
);
    import gcbd_pkg::*;

    logic [CAT_W-1:0]    left;
    logic [CAT_W-1:0]    cat;
    logic                emo;
    logic                par;
    logic                gb11;
    logic                brk;
    logic                left_ctl;
    logic                cat_ctl;
    logic [POINTS_W-1:0] pts_base;
    logic [BYTES_W-1:0]  bytes_base;
    logic [POINTS_W:0]   pts_sum;
    logic [BYTES_W:0]    bytes_sum;
    logic [POINTS_W-1:0] pts_sat;
    logic [BYTES_W-1:0]  bytes_sat;

    assign left     = i_state.previous_category;
    assign cat      = i_item.break_category;
    assign left_ctl = (left == CAT_CR) || (left == CAT_LF) || (left == CAT_CONTROL);
    assign cat_ctl  = (cat == CAT_CR) || (cat == CAT_LF) || (cat == CAT_CONTROL);

    // emoji zwj detector advances over the left point
    always_comb begin
        emo  = i_state.emoji_seq_state;
        gb11 = 1'b0;
        if (!i_state.emoji_seq_state) begin
            emo = i_state.previous_pictographic;
        end else if (left == CAT_ZWJ) begin
            emo  = 1'b0;
            gb11 = 1'b1;
        end else if (left != CAT_EXTEND) begin
            emo = i_state.previous_pictographic;
        end
    end

    assign par = (left == CAT_RI) ? ~i_state.regional_parity : 1'b0;

    always_comb begin
        if (i_item.text_start || !i_state.have_previous) begin
            brk = 1'b1;
        end else if (left == CAT_CR && cat == CAT_LF) begin
            brk = 1'b0;
        end else if (left_ctl || cat_ctl) begin
            brk = 1'b1;
        end else if (left == CAT_L && (cat == CAT_L || cat == CAT_V ||
                                       cat == CAT_LV || cat == CAT_LVT)) begin
            brk = 1'b0;
        end else if ((left == CAT_LV || left == CAT_V) && (cat == CAT_V || cat == CAT_T)) begin
            brk = 1'b0;
        end else if ((left == CAT_LVT || left == CAT_T) && cat == CAT_T) begin
            brk = 1'b0;
        end else if (cat == CAT_EXTEND || cat == CAT_ZWJ || cat == CAT_SPACING) begin
            brk = 1'b0;
        end else if (left == CAT_PREPEND) begin
            brk = 1'b0;
        end else if (gb11 && i_item.ext_pictographic) begin
            brk = 1'b0;
        end else if (left == CAT_RI && cat == CAT_RI && par) begin
            brk = 1'b0;
        end else begin
            brk = 1'b1;
        end
    end

    assign pts_base   = brk ? '0 : i_state.point_count;
    assign bytes_base = brk ? '0 : i_state.byte_count;
    assign pts_sum    = {1'b0, pts_base} + {{POINTS_W{1'b0}}, 1'b1};
    assign bytes_sum  = {1'b0, bytes_base} + {{(BYTES_W-SRC_BYTES_W+1){1'b0}}, i_item.source_bytes};
    assign pts_sat    = (pts_sum > {1'b0, POINTS_LIMIT}) ? POINTS_LIMIT : pts_sum[POINTS_W-1:0];
    assign bytes_sat  = (bytes_sum > {1'b0, BYTES_LIMIT}) ? BYTES_LIMIT : bytes_sum[BYTES_W-1:0];

    always_comb begin
        if (!i_item.code_valid) begin
            o_state                  = GCBD_STATE_RESET;
            o_result.boundary_before = 1'b1;
            o_result.cluster_points  = '0;
            o_result.cluster_bytes   = '0;
            o_result.decode_error    = 1'b1;
        end else begin
            o_state.have_previous         = 1'b1;
            o_state.previous_category     = cat;
            o_state.previous_pictographic = i_item.ext_pictographic;
            o_state.emoji_seq_state       = brk ? 1'b0 : emo;
            o_state.regional_parity       = brk ? 1'b0 : par;
            o_state.point_count           = pts_sat;
            o_state.byte_count            = bytes_sat;
            o_result.boundary_before      = brk;
            o_result.cluster_points       = pts_sat;
            o_result.cluster_bytes        = bytes_sat;
            o_result.decode_error         = 1'b0;
        end
    end

endmodule

/* sv/grapheme_cluster_boundary_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grapheme_cluster_boundary_detector_unit
// extended grapheme cluster boundary detection over a code point stream
// ----------------------------------------------------------------------------
// path: input beat to result beat through the input register, then the result register
// throughput: one code point per cycle unless i_m_tready stalls; state loop is one register
// reset: synchronous active low, clears both valid flags and the cluster state
// a stalled result register holds the input register, which still takes one beat
`include "grapheme_cluster_boundary_detector_unit_assert.svh"

module grapheme_cluster_boundary_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // break_category[3:0], ext_pictographic[4], source_bytes[7:5]
    input  logic [1:0]  i_s_tuser,  // text_start[0], code_valid[1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // cluster_points[7:0], cluster_bytes[17:8], zero[23:18]
    output logic [1:0]  o_m_tuser   // boundary_before[0], decode_error[1]
);
    import gcbd_pkg::*;

    logic         r_in_valid;
    t_gcbd_item   r_in;
    logic         r_out_valid;
    t_gcbd_result r_out;
    t_gcbd_state  r_state;
    t_gcbd_state  n_state;
    t_gcbd_result n_out;
    t_gcbd_item   in_item;
    logic         advance;

    assign in_item.break_category   = i_s_tdata[3:0];
    assign in_item.ext_pictographic = i_s_tdata[4];
    assign in_item.source_bytes     = i_s_tdata[7:5];
    assign in_item.text_start       = i_s_tuser[0];
    assign in_item.code_valid       = i_s_tuser[1];

    // move the held beat into the result register when that slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    gcbd_rules u_rules (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= GCBD_STATE_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.cluster_bytes, r_out.cluster_points};
    assign o_m_tuser  = {r_out.decode_error, r_out.boundary_before};

    `GCBD_ASSERT_SAME(a_error_clears, i_clk, i_rst_n, r_out_valid && r_out.decode_error, r_out.boundary_before && r_out.cluster_points == '0 && r_out.cluster_bytes == '0)
    `GCBD_ASSERT_SAME(a_points_nonzero, i_clk, i_rst_n, r_out_valid && !r_out.decode_error, r_out.cluster_points != '0)
    `GCBD_ASSERT_NEXT(a_invalid_drops_state, i_clk, i_rst_n, advance && !r_in.code_valid, !r_state.have_previous && r_state.point_count == '0)

endmodule

/* test/grapheme_cluster_boundary_detector_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grapheme cluster boundary detector testbench
// streams decoded code points into the detector and checks every result beat
// against an in-bench segmentation model: a directed table first, then random
// well-formed clusters (hangul, emoji zwj chains, flag pairs, cr lf, prepend),
// one saturating run, noise and invalid points, with random gaps and stalls
// ----------------------------------------------------------------------------
module grapheme_cluster_boundary_detector_unit_tb;
    import gcbd_pkg::*;

    localparam int ITEMS_TARGET = 1100;
    localparam logic [CAT_W-1:0] CAT_SPARE_LO = 4'd14;
    localparam logic [CAT_W-1:0] CAT_SPARE_HI = 4'd15;

    typedef struct {
        t_gcbd_item   pt;
        bit           typed;
        t_gcbd_result res;
    } t_seg_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // break_category[3:0], ext_pictographic[4], source_bytes[7:5]
    logic [1:0]  i_s_tuser;   // text_start[0], code_valid[1]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // cluster_points[7:0], cluster_bytes[17:8], zero[23:18]
    logic [1:0]  o_m_tuser;   // boundary_before[0], decode_error[1]

    t_gcbd_state  seg;
    t_gcbd_result cluster_q[$];
    t_seg_row     dir_rows[$];
    int           err_count;
    int           sent;
    bit           gap_mode;

    grapheme_cluster_boundary_detector_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit is_control(input logic [CAT_W-1:0] c);
        return c == CAT_CR || c == CAT_LF || c == CAT_CONTROL;
    endfunction

    function automatic t_gcbd_item mk(input bit start, input logic [CAT_W-1:0] cat,
                                      input bit pict, input int nbytes, input bit valid);
        t_gcbd_item pt;
        pt.text_start       = start;
        pt.break_category   = cat;
        pt.ext_pictographic = pict;
        pt.source_bytes     = nbytes[SRC_BYTES_W-1:0];
        pt.code_valid       = valid;
        return pt;
    endfunction

    // advances the cluster state by one code point and returns its result beat
    function automatic t_gcbd_result segment_point(input t_gcbd_item pt);
        t_gcbd_result     res;
        logic [CAT_W-1:0] left;
        logic [CAT_W-1:0] cat;
        logic             emo;
        logic             par;
        bit               gb11;
        bit               brk;
        int               pc;
        int               bc;
        cat = pt.break_category;
        if (!pt.code_valid) begin
            seg = GCBD_STATE_RESET;
            res = '{1'b1, '0, '0, 1'b1};
            return res;
        end
        if (pt.text_start || !seg.have_previous) begin
            brk = 1'b1;
        end else begin
            left = seg.previous_category;
            emo  = seg.emoji_seq_state;
            par  = seg.regional_parity;
            gb11 = 1'b0;
            if (!emo) begin
                if (seg.previous_pictographic) emo = 1'b1;
            end else if (left == CAT_ZWJ) begin
                emo  = 1'b0;
                gb11 = 1'b1;
            end else if (left != CAT_EXTEND) begin
                // restart, possibly straight back into the pictographic state
                emo = seg.previous_pictographic;
            end
            par = (left == CAT_RI) ? ~par : 1'b0;

            if (left == CAT_CR && cat == CAT_LF) brk = 1'b0;
            else if (is_control(left) || is_control(cat)) brk = 1'b1;
            else if (left == CAT_L &&
                     (cat == CAT_L || cat == CAT_V || cat == CAT_LV || cat == CAT_LVT))
                brk = 1'b0;
            else if ((left == CAT_LV || left == CAT_V) && (cat == CAT_V || cat == CAT_T))
                brk = 1'b0;
            else if ((left == CAT_LVT || left == CAT_T) && cat == CAT_T) brk = 1'b0;
            else if (cat == CAT_EXTEND || cat == CAT_ZWJ || cat == CAT_SPACING) brk = 1'b0;
            else if (left == CAT_PREPEND) brk = 1'b0;
            else if (gb11 && pt.ext_pictographic) brk = 1'b0;
            else if (left == CAT_RI && cat == CAT_RI && par) brk = 1'b0;
            else brk = 1'b1;

            seg.emoji_seq_state = emo;
            seg.regional_parity = par;
        end
        if (brk) begin
            seg.emoji_seq_state = 1'b0;
            seg.regional_parity = 1'b0;
            seg.point_count     = '0;
            seg.byte_count      = '0;
        end
        pc = int'(seg.point_count) + 1;
        if (pc > POINTS_LIMIT_INT) pc = POINTS_LIMIT_INT;
        bc = int'(seg.byte_count) + int'(pt.source_bytes);
        if (bc > int'(BYTES_LIMIT)) bc = int'(BYTES_LIMIT);
        seg.point_count           = pc[POINTS_W-1:0];
        seg.byte_count            = bc[BYTES_W-1:0];
        seg.have_previous         = 1'b1;
        seg.previous_category     = cat;
        seg.previous_pictographic = pt.ext_pictographic;
        res.boundary_before = brk;
        res.cluster_points  = seg.point_count;
        res.cluster_bytes   = seg.byte_count;
        res.decode_error    = 1'b0;
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_point(input t_gcbd_item pt, input bit typed,
                              input t_gcbd_result typed_res);
        t_gcbd_result res;
        int           gap;
        int           r;
        gap = 0;
        if (gap_mode) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(8, 30);
            else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pt.source_bytes, pt.ext_pictographic, pt.break_category};
        i_s_tuser  <= {pt.code_valid, pt.text_start};
        do @(posedge i_clk); while (!o_s_tready);
        res = segment_point(pt);
        cluster_q.push_back(typed ? typed_res : res);
        sent++;
        @(negedge i_clk);
    endtask

    // valid, non-start point with mostly legal byte lengths
    task automatic feed(input logic [CAT_W-1:0] cat, input bit pict);
        int nb;
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        send_point(mk(1'b0, cat, pict, nb, 1'b1), 1'b0, '0);
    endtask

    function automatic bit rare_pict();
        return $urandom_range(0, 7) == 0;
    endfunction

    // result beat checker
    always @(posedge i_clk) begin : result_check
        t_gcbd_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cluster_q.size() == 0) begin
                $error("result beat with no code point pending");
                err_count++;
            end else begin
                want = cluster_q.pop_front();
                if (o_m_tuser[0] !== want.boundary_before) begin
                    $error("boundary_before: expected %0d, got %0d",
                           want.boundary_before, o_m_tuser[0]);
                    err_count++;
                end
                if (o_m_tdata[7:0] !== want.cluster_points) begin
                    $error("cluster_points: expected %0d, got %0d",
                           want.cluster_points, o_m_tdata[7:0]);
                    err_count++;
                end
                if (o_m_tdata[17:8] !== want.cluster_bytes) begin
                    $error("cluster_bytes: expected %0d, got %0d",
                           want.cluster_bytes, o_m_tdata[17:8]);
                    err_count++;
                end
                if (o_m_tuser[1] !== want.decode_error) begin
                    $error("decode_error: expected %0d, got %0d",
                           want.decode_error, o_m_tuser[1]);
                    err_count++;
                end
            end
        end
    end

    // result side backpressure: stretches of free flow and of random stalls
    initial begin : result_ready
        int span;
        int stall;
        bit busy;
        i_m_tready = 1'b0;
        stall      = 0;
        @(posedge i_rst_n);
        forever begin
            busy = $urandom_range(0, 2) != 0;
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(negedge i_clk);
                if (busy && stall == 0 && $urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    stall--;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int n;
        int r;
        int k;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        seg        = GCBD_STATE_RESET;
        err_count  = 0;
        sent       = 0;
        gap_mode   = 1'b0;

        // first point after reset starts a cluster on its own
        dir_rows.push_back('{mk(1'b0, CAT_OTHER, 1'b0, 1, 1'b1), 1'b1, '{1'b1, 8'd1, 10'd1, 1'b0}});
        dir_rows.push_back('{mk(1'b0, CAT_CR, 1'b0, 1, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_LF, 1'b0, 1, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_CONTROL, 1'b0, 2, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_L, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_V, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_T, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_LV, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_T, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_LVT, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_T, 1'b0, 3, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_PREPEND, 1'b0, 2, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_SPARE_HI, 1'b1, 7, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_EXTEND, 1'b0, 0, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_ZWJ, 1'b0, 4, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_OTHER, 1'b1, 4, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_SPACING, 1'b0, 5, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_RI, 1'b0, 4, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_RI, 1'b0, 4, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_RI, 1'b0, 4, 1'b1), 1'b0, '0});
        dir_rows.push_back('{mk(1'b0, CAT_SPARE_LO, 1'b0, 6, 1'b1), 1'b0, '0});
        // invalid point with every other bit set
        dir_rows.push_back('{mk(1'b1, CAT_SPARE_HI, 1'b1, 7, 1'b0), 1'b1,
                             '{1'b1, 8'd0, 10'd0, 1'b1}});
        dir_rows.push_back('{mk(1'b0, CAT_EXTEND, 1'b0, 3, 1'b1), 1'b1,
                             '{1'b1, 8'd1, 10'd3, 1'b0}});
        dir_rows.push_back('{mk(1'b1, CAT_EXTEND, 1'b0, 2, 1'b1), 1'b1,
                             '{1'b1, 8'd1, 10'd2, 1'b0}});
        dir_rows.push_back('{mk(1'b0, CAT_CR, 1'b0, 1, 1'b1), 1'b0, '0});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].res);

        // one long cluster saturating both counts
        gap_mode = 1'b1;
        feed(CAT_OTHER, 1'b0);
        repeat (280)
            send_point(mk(1'b0, CAT_EXTEND, 1'b0, $urandom_range(4, 7), 1'b1), 1'b0, '0);

        while (sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 39) == 0) gap_mode = ~gap_mode;
            case ($urandom_range(0, 11))
                0, 1: begin
                    // hangul syllable
                    repeat ($urandom_range(0, 3)) feed(CAT_L, 1'b0);
                    r = $urandom_range(0, 2);
                    if (r == 0) begin
                        repeat ($urandom_range(1, 2)) feed(CAT_V, 1'b0);
                    end else if (r == 1) begin
                        feed(CAT_LV, 1'b0);
                        if ($urandom_range(0, 1)) feed(CAT_V, 1'b0);
                    end else begin
                        feed(CAT_LVT, 1'b0);
                    end
                    repeat ($urandom_range(0, 2)) feed(CAT_T, 1'b0);
                    if ($urandom_range(0, 3) == 0) feed(CAT_EXTEND, 1'b0);
                end
                2, 3: begin
                    // emoji zwj chain, links sometimes not pictographic
                    feed(CAT_OTHER, 1'b1);
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++) begin
                        repeat ($urandom_range(0, 1)) feed(CAT_EXTEND, 1'b0);
                        feed(CAT_ZWJ, 1'b0);
                        feed(CAT_OTHER, $urandom_range(0, 4) != 0);
                    end
                end
                4: repeat ($urandom_range(1, 6)) feed(CAT_RI, 1'b0);
                5: begin
                    r = $urandom_range(0, 4);
                    if (r == 0) begin
                        feed(CAT_CR, 1'b0);
                        feed(CAT_LF, 1'b0);
                    end else if (r == 1) begin
                        feed(CAT_CR, 1'b0);
                    end else if (r == 2) begin
                        feed(CAT_LF, 1'b0);
                    end else if (r == 3) begin
                        feed(CAT_CONTROL, rare_pict());
                    end else begin
                        feed(CAT_CR, 1'b0);
                        feed(CAT_CR, 1'b0);
                        feed(CAT_LF, 1'b0);
                    end
                end
                6: begin
                    repeat ($urandom_range(1, 2)) feed(CAT_PREPEND, 1'b0);
                    feed(CAT_W'($urandom_range(0, 15)), rare_pict());
                    repeat ($urandom_range(0, 3))
                        feed($urandom_range(0, 1) ? CAT_SPACING : CAT_EXTEND, 1'b0);
                end
                7: begin
                    feed(CAT_OTHER, rare_pict());
                    repeat ($urandom_range(0, 4)) begin
                        r = $urandom_range(0, 2);
                        feed(r == 0 ? CAT_EXTEND : (r == 1 ? CAT_ZWJ : CAT_SPACING),
                             rare_pict());
                    end
                end
                8: begin
                    // noise
                    repeat ($urandom_range(1, 4))
                        send_point(mk($urandom_range(0, 7) == 0,
                                      CAT_W'($urandom_range(0, 15)),
                                      1'($urandom_range(0, 1)), $urandom_range(0, 7),
                                      $urandom_range(0, 5) != 0), 1'b0, '0);
                end
                9: send_point(mk(1'($urandom_range(0, 1)), CAT_W'($urandom_range(0, 15)),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 7), 1'b0),
                              1'b0, '0);
                10: send_point(mk(1'b1, CAT_W'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)), $urandom_range(1, 4), 1'b1),
                               1'b0, '0);
                default: begin
                    feed($urandom_range(0, 1) ? CAT_SPARE_LO : CAT_SPARE_HI, rare_pict());
                    repeat ($urandom_range(0, 2)) feed(CAT_EXTEND, 1'b0);
                end
            endcase
        end
        i_s_tvalid <= 1'b0;

        while (cluster_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && cluster_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
